// ===== hw/rtl/crc_rx_pkg.sv =====
// Package for the CRC-checked frame receiver: controller states, the command and
// status structs that join controller and datapath, and the CRC constants.
// Depends on nothing; every other file of the block takes its names from here.
package crc_rx_pkg;

   // Default frame length in bytes, header and trailing CRC included.
   localparam int FRAME_BYTES_DEFAULT = 32;

   // CRC-16/CCITT-FALSE constants.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HDR_LO,
      ST_HDR_HI,
      ST_CRC,
      ST_TRL_LO,
      ST_TRL_HI,
      ST_EMIT,
      ST_NOTICE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_byte;     // store the incoming byte behind the pending bytes
      logic idx_clr;     // offset counter back to zero
      logic idx_inc;     // offset counter forward by one
      logic cap_lo;      // hold the byte just read as a low byte
      logic crc_init;    // load the CRC seed
      logic crc_upd;     // fold the byte just read into the CRC
      logic drop;        // drop the leading pending byte
      logic clear_fill;  // empty the window
      logic load_frame;  // put a frame byte into the output register
      logic load_notice; // put a failure notice into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_ge2;    // two or more bytes pending
      logic fill_full;   // a whole frame is pending
      logic hdr_match;   // the two bytes read match the sync word
      logic crc_match;   // the two bytes read match the computed CRC
      logic idx_crc_end; // the byte at the offset is the last one under the CRC
      logic idx_last;    // the offset points at the final byte of the frame
      logic out_free;    // the output register can take an item this cycle
   } status_type;

endpackage

// ===== hw/rtl/crc_checked_frame_receiver_core.sv =====
// Top level of the CRC-checked frame receiver: joins the controller and the datapath.
// Depends on crc_rx_pkg, crc_rx_ctrl and crc_rx_dp.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_rx_byte
//   rsp_     out        rsp_valid/rsp_stall  rsp_kind, rsp_frame_byte, rsp_last,
//                                            rsp_lost_total
//   csr_     in         csr_valid/csr_ready  csr_header_word
//
// A byte is taken in ST_IDLE; a header check then runs ST_CHECK, ST_HDR_LO, ST_HDR_HI,
// and a failed check drops one byte and checks again. A full matching window runs the
// CRC one byte a cycle out of the single read port over FRAME_BYTES - 2 bytes, then
// reads the trailer; a good frame leaves FRAME_BYTES items, one a cycle unless stalled.
// req_stall is high from the accepted byte until scanning is done; a stalled result
// holds the sequencer. Reset is synchronous and clears the fill, lost count and sync word.
module crc_checked_frame_receiver_core #(
   parameter int FRAME_BYTES = crc_rx_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last,
   output logic [15:0] rsp_lost_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_header_word
);

   crc_rx_pkg::cmd_type    cmd;
   crc_rx_pkg::status_type status;

   // The sync word register takes a write in any cycle.
   assign csr_ready = 1'b1;

   crc_rx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   crc_rx_dp #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_rx_byte     (req_rx_byte),
      .csr_valid       (csr_valid && csr_ready),
      .csr_header_word (csr_header_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last        (rsp_last),
      .rsp_lost_total  (rsp_lost_total)
   );

endmodule

// ===== hw/rtl/crc_rx_ctrl.sv =====
// Controller of the CRC-checked frame receiver: a state machine that scans for the
// header, steps the CRC over the window and sequences the output items.
// Depends on crc_rx_pkg for the state enum and the command and status structs.
module crc_rx_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  crc_rx_pkg::status_type status,
   output crc_rx_pkg::cmd_type    cmd
);

   crc_rx_pkg::state_type state_ff;
   crc_rx_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc_rx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crc_rx_pkg::ST_IDLE: begin
            if (req_valid) state_in = crc_rx_pkg::ST_CHECK;
         end
         crc_rx_pkg::ST_CHECK: begin
            state_in = status.fill_ge2 ? crc_rx_pkg::ST_HDR_LO : crc_rx_pkg::ST_IDLE;
         end
         crc_rx_pkg::ST_HDR_LO: begin
            state_in = crc_rx_pkg::ST_HDR_HI;
         end
         crc_rx_pkg::ST_HDR_HI: begin
            if (!status.hdr_match) begin
               state_in = crc_rx_pkg::ST_CHECK;
            end else if (!status.fill_full) begin
               state_in = crc_rx_pkg::ST_IDLE;
            end else begin
               state_in = crc_rx_pkg::ST_CRC;
            end
         end
         crc_rx_pkg::ST_CRC: begin
            if (status.idx_crc_end) state_in = crc_rx_pkg::ST_TRL_LO;
         end
         crc_rx_pkg::ST_TRL_LO: begin
            state_in = crc_rx_pkg::ST_TRL_HI;
         end
         crc_rx_pkg::ST_TRL_HI: begin
            state_in = status.crc_match ? crc_rx_pkg::ST_EMIT : crc_rx_pkg::ST_NOTICE;
         end
         crc_rx_pkg::ST_EMIT: begin
            if (status.out_free && status.idx_last) state_in = crc_rx_pkg::ST_IDLE;
         end
         crc_rx_pkg::ST_NOTICE: begin
            if (status.out_free) state_in = crc_rx_pkg::ST_CHECK;
         end
         default: begin
            state_in = crc_rx_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         crc_rx_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.wr_byte = req_valid;
         end
         crc_rx_pkg::ST_CHECK: begin
            cmd.idx_clr = 1'b1;
         end
         crc_rx_pkg::ST_HDR_LO: begin
            cmd.cap_lo  = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         crc_rx_pkg::ST_HDR_HI: begin
            // A mismatch drops one byte; a full matching window starts the CRC.
            cmd.drop     = !status.hdr_match;
            cmd.idx_clr  = 1'b1;
            cmd.crc_init = status.hdr_match && status.fill_full;
         end
         crc_rx_pkg::ST_CRC: begin
            cmd.crc_upd = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         crc_rx_pkg::ST_TRL_LO: begin
            cmd.cap_lo  = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         crc_rx_pkg::ST_TRL_HI: begin
            cmd.idx_clr = 1'b1;
         end
         crc_rx_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_frame = 1'b1;
               cmd.idx_inc    = !status.idx_last;
               cmd.idx_clr    = status.idx_last;
               cmd.clear_fill = status.idx_last;
            end
         end
         crc_rx_pkg::ST_NOTICE: begin
            if (status.out_free) begin
               cmd.load_notice = 1'b1;
               cmd.drop        = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/crc_rx_dp.sv =====
// Datapath of the CRC-checked frame receiver: circular window memory, fill and
// offset counters, CRC register, lost-frame counter, sync word and output register.
// Depends on crc_rx_pkg for the command and status structs and the CRC constants.
module crc_rx_dp #(
   parameter int FRAME_BYTES = crc_rx_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crc_rx_pkg::cmd_type    cmd,
   output crc_rx_pkg::status_type status,
   input  logic [7:0]             req_rx_byte,
   input  logic                   csr_valid,
   input  logic [15:0]            csr_header_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last,
   output logic [15:0]            rsp_lost_total
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int FW = $clog2(FRAME_BYTES + 1);
   localparam logic [AW:0]   FB_WRAP     = (AW + 1)'(FRAME_BYTES);
   localparam logic [FW-1:0] FILL_FULL   = FW'(FRAME_BYTES);
   localparam logic [FW-1:0] FILL_TWO    = FW'(2);
   localparam logic [AW-1:0] IDX_CRC_END = AW'(FRAME_BYTES - 3);
   localparam logic [AW-1:0] IDX_LAST    = AW'(FRAME_BYTES - 1);

   // Address addition modulo the window length; both operands stay below it.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = (AW + 1)'(a) + (AW + 1)'(b);
      if (s >= FB_WRAP) s = s - FB_WRAP;
      return s[AW-1:0];
   endfunction

   // One byte of CRC-16/CCITT-FALSE, most significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if ((c & crc_rx_pkg::CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ crc_rx_pkg::CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   logic [7:0]    window_mem [FRAME_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] idx_ff,  idx_in;
   logic [15:0]   lost_ff, lost_in;
   logic [15:0]   header_ff;
   logic [15:0]   crc_ff,  crc_in;
   logic [7:0]    lo_ff,   lo_in;

   logic          out_valid_ff, out_valid_in;
   logic          out_kind_ff,  out_kind_in;
   logic [7:0]    out_byte_ff,  out_byte_in;
   logic          out_last_ff,  out_last_in;
   logic [15:0]   out_lost_ff,  out_lost_in;
   logic          out_free;

   // Window pointers and counters.
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      idx_in  = idx_ff;
      lost_in = lost_ff;
      if (cmd.wr_byte) fill_in = fill_ff + FW'(1);
      if (cmd.drop) begin
         head_in = wrap_add(head_ff, AW'(1));
         fill_in = fill_ff - FW'(1);
      end
      if (cmd.clear_fill) fill_in = '0;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.load_notice) lost_in = lost_ff + 16'd1;
   end

   // The read address follows the next pointer values, so the registered read data
   // in each state is the byte at the current head plus offset.
   assign rd_addr = wrap_add(head_in, idx_in);
   assign wr_addr = wrap_add(head_ff, fill_ff[AW-1:0]);

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_byte) window_mem[wr_addr] <= req_rx_byte;
      rd_data_ff <= window_mem[rd_addr];
   end

   // CRC and captured low byte.
   always_comb begin
      crc_in = crc_ff;
      lo_in  = lo_ff;
      if (cmd.crc_init) begin
         crc_in = crc_rx_pkg::CRC_INIT;
      end else if (cmd.crc_upd) begin
         crc_in = crc_byte(crc_ff, rd_data_ff);
      end
      if (cmd.cap_lo) lo_in = rd_data_ff;
   end

   // Output register: it takes a new item when empty or when its item leaves.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_lost_in  = out_lost_ff;
      if (!rsp_stall) out_valid_in = 1'b0;
      if (cmd.load_frame) begin
         out_valid_in = 1'b1;
         out_kind_in  = 1'b0;
         out_byte_in  = rd_data_ff;
         out_last_in  = status.idx_last;
         out_lost_in  = lost_ff;
      end else if (cmd.load_notice) begin
         out_valid_in = 1'b1;
         out_kind_in  = 1'b1;
         out_byte_in  = 8'h00;
         out_last_in  = 1'b1;
         out_lost_in  = lost_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         lost_ff      <= '0;
         header_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         lost_ff      <= lost_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) header_ff <= csr_header_word;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      crc_ff      <= crc_in;
      lo_ff       <= lo_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_lost_ff <= out_lost_in;
   end

   // Status towards the controller.
   always_comb begin
      status.fill_ge2    = fill_ff >= FILL_TWO;
      status.fill_full   = fill_ff == FILL_FULL;
      status.hdr_match   = {rd_data_ff, lo_ff} == header_ff;
      status.crc_match   = {rd_data_ff, lo_ff} == crc_ff;
      status.idx_crc_end = idx_ff == IDX_CRC_END;
      status.idx_last    = idx_ff == IDX_LAST;
      status.out_free    = out_free;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_lost_total = out_lost_ff;

   // The window never holds more than one frame.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill beyond frame length");

   // A byte is only stored while the window has room.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_byte |-> fill_ff < FILL_FULL)
      else $error("byte written into a full window");

   // The output register is never overwritten while its item is held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_frame || cmd.load_notice) |-> out_free)
      else $error("output item overwritten under stall");

   // A failure notice carries a zero byte and closes its own sequence.
   a_notice_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff) |-> (out_last_ff && out_byte_ff == 8'h00))
      else $error("malformed failure notice");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crc_checked_frame_receiver_core: feeds received bytes,
// deframes them alongside the block and checks every frame byte and failure notice.
// Depends on crc_rx_pkg and the RTL of the block.
module tb_top;

   localparam int FB            = crc_rx_pkg::FRAME_BYTES_DEFAULT;
   localparam int STUCK_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 300;
   localparam int REPORT_MAX    = 10;
   localparam bit KIND_DATA     = 1'b0;
   localparam bit KIND_NOTICE   = 1'b1;

   typedef enum {SEQ_GOOD, SEQ_BAD, SEQ_NOISE, SEQ_CUT, SEQ_SYNC} seq_kind_type;

   typedef struct {
      bit        kind;
      bit [7:0]  frame_byte;
      bit        last;
      bit [15:0] lost_total;
   } rsp_item_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte     = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last;
   logic [15:0] rsp_lost_total;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_header_word = 16'h0000;

   // Bytes waiting to be sent, and frame output that the block still owes.
   bit [7:0]     rx_pending [$];
   rsp_item_type frame_out_q [$];

   // Deframer state kept by the testbench.
   bit [FB-1:0][7:0] win;
   int unsigned      win_fill   = 0;
   bit [15:0]        lost_count = 16'h0000;
   bit [15:0]        sync_word  = 16'h0000;

   int unsigned  stuck_cycles    = 0;
   int unsigned  idle_left       = 0;
   int unsigned  stall_left      = 0;
   int unsigned  mismatches      = 0;
   int unsigned  bytes_in        = 0;
   int unsigned  bytes_queued    = 0;
   int unsigned  good_bytes_seen = 0;
   int unsigned  notices_seen    = 0;
   int unsigned  headers_set     = 0;
   bit           steady          = 1'b0;
   bit           holding;
   rsp_item_type want;

   crc_checked_frame_receiver_core #(
      .FRAME_BYTES(FB)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last       (rsp_last),
      .rsp_lost_total (rsp_lost_total),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_header_word(csr_header_word)
   );

   always #10 clock = ~clock;

   // CRC-16/CCITT-FALSE over every byte of a frame but the trailing two.
   function automatic bit [15:0] frame_crc(input bit [FB-1:0][7:0] data);
      bit [15:0] crc;
      crc = crc_rx_pkg::CRC_INIT;
      for (int i = 0; i < FB - 2; i++) begin
         crc ^= {data[i], 8'h00};
         for (int b = 0; b < 8; b++)
            crc = ((crc & crc_rx_pkg::CRC_MSB) != 16'h0000) ?
                  ((crc << 1) ^ crc_rx_pkg::CRC_POLY) : (crc << 1);
      end
      return crc;
   endfunction

   // Idle length: mostly short, now and then long, none while running steady.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (steady || r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(15, 4);
      return $urandom_range(80, 20);
   endfunction

   // Payload byte with the extremes favoured.
   function automatic bit [7:0] rand_byte();
      case ($urandom_range(9, 0))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Takes one received byte through the deframer and queues the output it causes.
   task automatic deframe_byte(input bit [7:0] b);
      rsp_item_type it;
      if (win_fill < FB) begin
         win[win_fill] = b;
         win_fill++;
      end
      while (win_fill >= 2) begin
         if ({win[1], win[0]} != sync_word) begin
            win >>= 8;
            win_fill--;
         end else if (win_fill < FB) begin
            break;
         end else if (frame_crc(win) == {win[FB-1], win[FB-2]}) begin
            for (int i = 0; i < FB; i++) begin
               it.kind       = KIND_DATA;
               it.frame_byte = win[i];
               it.last       = (i == FB - 1);
               it.lost_total = lost_count;
               frame_out_q.push_back(it);
            end
            win_fill = 0;
            break;
         end else begin
            // A rejected frame gives one notice and loses its leading byte.
            lost_count++;
            it.kind       = KIND_NOTICE;
            it.frame_byte = 8'h00;
            it.last       = 1'b1;
            it.lost_total = lost_count;
            frame_out_q.push_back(it);
            win >>= 8;
            win_fill--;
         end
      end
   endtask

   task automatic queue_byte(input bit [7:0] b);
      rx_pending.push_back(b);
      bytes_queued++;
   endtask

   // Queues one frame behind the current sync word; a bad one has a single bit flipped.
   task automatic queue_frame(input bit good, input bit fixed, input bit [7:0] fixed_byte);
      bit [FB-1:0][7:0] f;
      bit [15:0]        crc;
      int unsigned      pos;
      f[0] = sync_word[7:0];
      f[1] = sync_word[15:8];
      for (int i = 2; i < FB - 2; i++)
         f[i] = fixed ? fixed_byte : rand_byte();
      crc       = frame_crc(f);
      f[FB - 2] = crc[7:0];
      f[FB - 1] = crc[15:8];
      if (!good) begin
         pos    = $urandom_range(FB - 1, 2);
         f[pos] ^= 8'h01 << $urandom_range(7, 0);
      end
      for (int i = 0; i < FB; i++)
         queue_byte(f[i]);
   endtask

   // Mostly well-formed frames, with corrupt frames, cut frames, stray sync words and noise.
   task automatic queue_random(input int unsigned n);
      int unsigned  target;
      int unsigned  r;
      seq_kind_type k;
      target = bytes_queued + n;
      while (bytes_queued < target) begin
         r = $urandom_range(99, 0);
         k = (r < 68) ? SEQ_GOOD : (r < 80) ? SEQ_BAD : (r < 88) ? SEQ_NOISE :
             (r < 94) ? SEQ_CUT : SEQ_SYNC;
         case (k)
            SEQ_GOOD: queue_frame(1'b1, 1'b0, 8'h00);
            SEQ_BAD:  queue_frame(1'b0, 1'b0, 8'h00);
            SEQ_NOISE: begin
               repeat ($urandom_range(6, 1))
                  queue_byte(8'($urandom));
            end
            SEQ_CUT: begin
               queue_byte(sync_word[7:0]);
               queue_byte(sync_word[15:8]);
               repeat ($urandom_range(FB - 3, 0))
                  queue_byte(rand_byte());
            end
            SEQ_SYNC: begin
               queue_byte(sync_word[7:0]);
               queue_byte(sync_word[15:8]);
            end
         endcase
      end
   endtask

   // Waits for every byte to be taken and every output to arrive, then lets scanning end.
   task automatic drain();
      do @(negedge clock); while (rx_pending.size() != 0 || req_valid);
      while (frame_out_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_header(input bit [15:0] value);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_header_word <= value;
      do @(posedge clock); while (!csr_ready);
      sync_word = value;
      headers_set++;
      csr_valid <= 1'b0;
   endtask

   // Byte sender: presents the next pending byte after a random idle stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         holding = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            bytes_in++;
            idle_left = pick_gap();
         end
         if (!holding) begin
            if (idle_left == 0 && rx_pending.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (idle_left > 0)
                  idle_left--;
            end
         end
      end
   end

   // Output checker: compares each item taken with the oldest one owed, and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_kind == KIND_NOTICE)
               notices_seen++;
            else
               good_bytes_seen++;
            if (frame_out_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected item kind=%0d byte=%02h last=%0d lost=%0d",
                           $realtime, rsp_kind, rsp_frame_byte, rsp_last, rsp_lost_total);
            end else begin
               want = frame_out_q.pop_front();
               if (rsp_kind !== want.kind || rsp_frame_byte !== want.frame_byte ||
                   rsp_last !== want.last || rsp_lost_total !== want.lost_total) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"%0t: item mismatch, expected kind=%0d byte=%02h last=%0d ",
                               "lost=%0d, got kind=%0d byte=%02h last=%0d lost=%0d"},
                              $realtime, want.kind, want.frame_byte, want.last,
                              want.lost_total, rsp_kind, rsp_frame_byte, rsp_last,
                              rsp_lost_total);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // Cycles since any handshake completed.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT)
         @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("crc_checked_frame_receiver_core regression: fail");
      $finish;
   end

   // Stimulus: a directed opening under the reset sync word, then random phases.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Lone byte, frames with all-zero and all-ones payloads, a corrupt frame, then a
      // run of zeros that matches the zero sync word again and again and keeps failing.
      queue_byte(8'hFF);
      queue_frame(1'b1, 1'b1, 8'h00);
      queue_frame(1'b1, 1'b1, 8'hFF);
      queue_frame(1'b0, 1'b0, 8'h00);
      repeat (40) queue_byte(8'h00);
      queue_random(40);
      drain();

      write_header(16'hFFFF);
      queue_frame(1'b1, 1'b1, 8'hFF);
      queue_random(60);
      drain();

      // A phase with no idling on either side.
      steady = 1'b1;
      write_header(16'h5AA5);
      queue_random(50);
      drain();
      steady = 1'b0;

      write_header(16'h0000);
      queue_random(30);
      drain();

      write_header(16'($urandom));
      queue_random(30);
      drain();

      $display("sent %0d bytes across %0d sync words written after reset", bytes_in,
               headers_set);
      $display("checked %0d good frame bytes and %0d failure notices, lost count %0d",
               good_bytes_seen, notices_seen, lost_count);
      if (mismatches == 0 && frame_out_q.size() == 0)
         $display("crc_checked_frame_receiver_core regression: pass");
      else
         $display("crc_checked_frame_receiver_core regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/crc_rx_pkg.sv
hw/rtl/crc_rx_ctrl.sv
hw/rtl/crc_rx_dp.sv
hw/rtl/crc_checked_frame_receiver_core.sv
tb/tb_top.sv
